// ===== rtl/bqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types, constants and index helpers for the biquad cascade core.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_STAGES_DEF   = 8;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  // fixed port field widths
  localparam int OP_W      = 2;
  localparam int CIDX_W    = 6;
  localparam int CVAL_W    = 32;
  localparam int SVAL_W    = 24;
  localparam int CFG_W     = 4;
  localparam int CFG_RESET = 1;

  // coefficient slots per stage: b0, b1, b2, a1, a2
  localparam int SLOTS  = 5;
  localparam int SLOT_W = 3;
  localparam int SLOT_B0 = 0;
  localparam int SLOT_B1 = 1;
  localparam int SLOT_B2 = 2;
  localparam int SLOT_A1 = 3;
  localparam int SLOT_A2 = 4;

  // delay word format Q7.40
  localparam int DELAY_W    = 48;
  localparam int DELAY_FRAC = 40;

  // default product Q0.23 x Q2.29 = Q.52, aligned to Q.68, rounded to Q.40
  localparam int PROD_EXT_W = 73;
  localparam int PROD_SHIFT = 28;
  localparam int PROD_W     = PROD_EXT_W - PROD_SHIFT;
  localparam int PROD_ALIGN = 72;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULB,
    ST_ACC,
    ST_MULA,
    ST_WB,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic start;
    logic mul_b;
    logic acc;
    logic mul_a;
  } dp_ctrl_t;

  // stage row of a coefficient index: floor(idx / 5) by reciprocal 205/1024
  function automatic logic [3:0] coef_row(input logic [CIDX_W-1:0] idx);
    logic [13:0] prod;
    prod = 14'(idx) * 14'd205;
    return prod[13:10];
  endfunction

  function automatic logic [SLOT_W-1:0] coef_slot(input logic [CIDX_W-1:0] idx);
    logic [CIDX_W-1:0] base;
    base = CIDX_W'(coef_row(idx)) * CIDX_W'(SLOTS);
    return SLOT_W'(idx - base);
  endfunction

endpackage

// ===== rtl/biquad_cascade_iir_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core
// Cascade of up to MAX_STAGES transposed direct form II biquads.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry an operation: load one coefficient
//   (coef_index = stage*5 + slot, slots b0 b1 b2 a1 a2), filter one sample,
//   or clear all delay words. Only a sample produces an output word
//   (out_valid/out_ready): the filtered sample and a clip flag.
//   cfg_wr_en/cfg_wr_data set the stage count n (0 acts as 1, values above
//   MAX_STAGES act as MAX_STAGES); write it only while the core is idle.
//   Loads and clears are done as they are accepted. A sample runs stage by
//   stage through three shared multipliers, in states MULB (b products),
//   ACC (accumulate and round) and MULA (a products), after READ fetches
//   the first stage's coefficient and delay rows; WB writes back the last
//   stage and loads the result into the output register, and the next word
//   is taken back in IDLE, so the core takes no new word while a sample runs.
//   Reset sets n to 1 and zeroes all delay words; coefficients are
//   undefined until loaded. A finished sample waits in the core while the
//   output register is full; the core takes no new word until it is handed
//   over.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_core
  import bqc_pkg::*;
#(
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [CIDX_W-1:0]        in_coef_index,
  input  logic signed [CVAL_W-1:0] in_coef_value,
  input  logic signed [SVAL_W-1:0] in_sample_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SVAL_W-1:0] out_filtered_sample,
  output logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data
);

  localparam int ROW_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  state_t                  state_r, state_nxt;
  logic [ROW_W-1:0]        stage_r, stage_nxt;
  logic [CFG_W-1:0]        stage_count_r;
  logic [ROW_W-1:0]        last_stage;
  logic                    accept;
  dp_ctrl_t                ctrl;
  logic                    mem_rd_en;
  logic [ROW_W-1:0]        mem_rd_row;
  logic                    dly_wr_en;
  logic [ROW_W-1:0]        dly_wr_row;
  logic                    dly_clr;
  logic                    coef_wr_en;
  logic                    out_load;
  logic                    out_valid_r;
  logic [SVAL_W-1:0]       out_sample_r;
  logic                    out_sat_r;

  logic [SLOTS-1:0][COEF_WIDTH-1:0] coef_row_data;
  logic signed [COEF_WIDTH-1:0]     coef_wr_data;
  logic [CVAL_W+COEF_WIDTH-1:0]     coef_ext;
  logic [3:0]                       coef_row_full;
  logic signed [DELAY_W-1:0]        rd_d1, rd_d2, wb_d1, wb_d2;
  logic signed [SAMPLE_WIDTH-1:0]   y;
  logic                             clip;
  logic [SAMPLE_WIDTH+SVAL_W-1:0]   y_ext;

  assign accept = in_valid && in_ready;

  // clamp the configured stage count into 1 .. MAX_STAGES
  always_comb begin
    if (stage_count_r == '0) begin
      last_stage = '0;
    end else if (int'(stage_count_r) > MAX_STAGES) begin
      last_stage = ROW_W'(MAX_STAGES - 1);
    end else begin
      last_stage = ROW_W'(stage_count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_count_r <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      stage_count_r <= cfg_wr_data;
    end
  end

  // coefficient write decode
  assign coef_row_full = coef_row(in_coef_index);
  assign coef_ext      = {{COEF_WIDTH{1'b0}}, in_coef_value};
  assign coef_wr_data  = $signed(coef_ext[COEF_WIDTH-1:0]);

  always_comb begin
    coef_wr_en = 1'b0;
    dly_clr    = 1'b0;
    if (accept) begin
      unique case (in_operation)
        OP_LOAD:  coef_wr_en = int'(in_coef_index) < SLOTS * MAX_STAGES;
        OP_CLEAR: dly_clr = 1'b1;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    stage_nxt  = stage_r;
    in_ready   = 1'b0;
    ctrl       = '0;
    mem_rd_en  = 1'b0;
    mem_rd_row = stage_r + 1'b1;
    dly_wr_en  = 1'b0;
    dly_wr_row = stage_r - 1'b1;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_operation == OP_SAMPLE) begin
          ctrl.start = 1'b1;
          stage_nxt  = '0;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        mem_rd_en  = 1'b1;
        mem_rd_row = stage_r;
        state_nxt  = ST_MULB;
      end
      ST_MULB: begin
        ctrl.mul_b = 1'b1;
        // retire the previous stage while this one multiplies
        dly_wr_en  = stage_r != '0;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc  = 1'b1;
        state_nxt = ST_MULA;
      end
      ST_MULA: begin
        ctrl.mul_a = 1'b1;
        if (stage_r != last_stage) begin
          mem_rd_en = 1'b1;
          stage_nxt = stage_r + 1'b1;
          state_nxt = ST_MULB;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        dly_wr_en  = 1'b1;
        dly_wr_row = stage_r;
        out_load   = !out_valid_r || out_ready;
        state_nxt  = out_load ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        out_load  = !out_valid_r || out_ready;
        state_nxt = out_load ? ST_IDLE : ST_HOLD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  assign y_ext = {{SVAL_W{1'b0}}, y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= y_ext[SVAL_W-1:0];
      out_sat_r    <= clip;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = $signed(out_sample_r);
  assign out_saturated       = out_sat_r;

  bqc_coef_mem #(
    .MAX_STAGES (MAX_STAGES),
    .COEF_WIDTH (COEF_WIDTH),
    .ROW_W      (ROW_W)
  ) u_coef_mem (
    .clk     (clk),
    .wr_en   (coef_wr_en),
    .wr_row  (coef_row_full[ROW_W-1:0]),
    .wr_slot (coef_slot(in_coef_index)),
    .wr_data (coef_wr_data),
    .rd_en   (mem_rd_en),
    .rd_row  (mem_rd_row),
    .rd_data (coef_row_data)
  );

  bqc_dly_mem #(
    .MAX_STAGES (MAX_STAGES),
    .ROW_W      (ROW_W)
  ) u_dly_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (dly_clr),
    .wr_en  (dly_wr_en),
    .wr_row (dly_wr_row),
    .wr_d1  (wb_d1),
    .wr_d2  (wb_d2),
    .rd_en  (mem_rd_en),
    .rd_row (mem_rd_row),
    .rd_d1  (rd_d1),
    .rd_d2  (rd_d2)
  );

  bqc_arith #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_arith (
    .clk   (clk),
    .ctrl  (ctrl),
    .x_in  (in_sample_value),
    .coef  (coef_row_data),
    .d1    (rd_d1),
    .d2    (rd_d2),
    .y     (y),
    .clip  (clip),
    .wb_d1 (wb_d1),
    .wb_d2 (wb_d2)
  );

endmodule

// ===== rtl/bqc_coef_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_coef_mem
// Coefficient store, one row of five coefficients per stage. Single words
// are written by slot; a whole row is read through an output register.
// ----------------------------------------------------------------------------
module bqc_coef_mem
  import bqc_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int ROW_W      = 3
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [ROW_W-1:0]                    wr_row,
  input  logic [SLOT_W-1:0]                   wr_slot,
  input  logic signed [COEF_WIDTH-1:0]        wr_data,
  input  logic                                rd_en,
  input  logic [ROW_W-1:0]                    rd_row,
  output logic [SLOTS-1:0][COEF_WIDTH-1:0]    rd_data
);

  logic [SLOTS-1:0][COEF_WIDTH-1:0] mem [MAX_STAGES];
  logic [SLOTS-1:0][COEF_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bqc_dly_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_dly_mem
// Delay word store, one row (d1, d2) per stage, with a registered read.
// Per-row valid bits make cleared rows read as zero.
// ----------------------------------------------------------------------------
module bqc_dly_mem
  import bqc_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int ROW_W      = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       wr_en,
  input  logic [ROW_W-1:0]           wr_row,
  input  logic signed [DELAY_W-1:0]  wr_d1,
  input  logic signed [DELAY_W-1:0]  wr_d2,
  input  logic                       rd_en,
  input  logic [ROW_W-1:0]           rd_row,
  output logic signed [DELAY_W-1:0]  rd_d1,
  output logic signed [DELAY_W-1:0]  rd_d2
);

  logic [1:0][DELAY_W-1:0] mem [MAX_STAGES];
  logic [MAX_STAGES-1:0]   valid_r;
  logic [DELAY_W-1:0]      rd_d1_r;
  logic [DELAY_W-1:0]      rd_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= {wr_d2, wr_d1};
    end
    if (rd_en) begin
      // never-written or cleared rows read as zero
      if (valid_r[rd_row]) begin
        rd_d1_r <= mem[rd_row][0];
        rd_d2_r <= mem[rd_row][1];
      end else begin
        rd_d1_r <= '0;
        rd_d2_r <= '0;
      end
    end
  end

  assign rd_d1 = $signed(rd_d1_r);
  assign rd_d2 = $signed(rd_d2_r);

endmodule

// ===== rtl/bqc_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_arith
// Stage arithmetic: three shared multipliers with rounding, the stage
// accumulator with output rounding and clipping, and the delay update.
// ----------------------------------------------------------------------------
module bqc_arith
  import bqc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  dp_ctrl_t                            ctrl,
  input  logic signed [SVAL_W-1:0]            x_in,
  input  logic [SLOTS-1:0][COEF_WIDTH-1:0]    coef,
  input  logic signed [DELAY_W-1:0]           d1,
  input  logic signed [DELAY_W-1:0]           d2,
  output logic signed [SAMPLE_WIDTH-1:0]      y,
  output logic                                clip,
  output logic signed [DELAY_W-1:0]           wb_d1,
  output logic signed [DELAY_W-1:0]           wb_d2
);

  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int K     = PROD_ALIGN - PW;
  localparam int RSH   = DELAY_FRAC + 1 - SAMPLE_WIDTH;
  localparam int ACC_W = DELAY_W + 2;
  localparam int XW    = ((SAMPLE_WIDTH > SVAL_W) ? SAMPLE_WIDTH : SVAL_W) + 1;

  localparam logic signed [ACC_W-1:0] YMAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] YMIN = -YMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] DMAX = (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] DMIN = -DMAX - ACC_W'(1);
  localparam logic signed [XW-1:0]    XMAX = (XW'(1) <<< (SAMPLE_WIDTH - 1)) - XW'(1);
  localparam logic signed [XW-1:0]    XMIN = -XMAX - XW'(1);
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (RSH - 1);

  // align to Q.68 and round half up to Q.40
  function automatic logic signed [PROD_W-1:0] rnd_q40(input logic signed [PW-1:0] p);
    logic signed [PROD_EXT_W-1:0] e;
    e = PROD_EXT_W'(p);
    e = (e <<< K) + (PROD_EXT_W'(1) <<< (PROD_SHIFT - 1));
    return e[PROD_EXT_W-1:PROD_SHIFT];
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] cur_r;
  logic                           clip_r;
  logic signed [PROD_W-1:0]       pb0_r, pb1_r, pb2_r, pa1_r, pa2_r;
  logic signed [DELAY_W-1:0]      d2_r;

  logic signed [COEF_WIDTH-1:0]   c0, c1, c2;
  logic signed [PW-1:0]           m0, m1, m2;
  logic signed [ACC_W-1:0]        acc, ys, s1, s2;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_clip;
  logic signed [XW-1:0]           x_ext;
  logic signed [SAMPLE_WIDTH-1:0] x_sat;

  // b products on the way in, a products on the feedback pass
  always_comb begin
    c0 = $signed(ctrl.mul_a ? coef[SLOT_A1] : coef[SLOT_B0]);
    c1 = $signed(ctrl.mul_a ? coef[SLOT_A2] : coef[SLOT_B1]);
    c2 = $signed(coef[SLOT_B2]);
    m0 = PW'(cur_r) * PW'(c0);
    m1 = PW'(cur_r) * PW'(c1);
    m2 = PW'(cur_r) * PW'(c2);
  end

  always_comb begin
    acc = ACC_W'(pb0_r) + ACC_W'(d1);
    ys  = (acc + RND) >>> RSH;
    y_clip = (ys > YMAX) || (ys < YMIN);
    if (ys > YMAX) begin
      y_sat = YMAX[SAMPLE_WIDTH-1:0];
    end else if (ys < YMIN) begin
      y_sat = YMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = ys[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    x_ext = XW'(x_in);
    if (x_ext > XMAX) begin
      x_sat = XMAX[SAMPLE_WIDTH-1:0];
    end else if (x_ext < XMIN) begin
      x_sat = XMIN[SAMPLE_WIDTH-1:0];
    end else begin
      x_sat = x_ext[SAMPLE_WIDTH-1:0];
    end
  end

  // delay update of the stage whose products sit in the registers
  always_comb begin
    s1 = ACC_W'(pb1_r) - ACC_W'(pa1_r) + ACC_W'(d2_r);
    s2 = ACC_W'(pb2_r) - ACC_W'(pa2_r);
    if (s1 > DMAX) begin
      wb_d1 = DMAX[DELAY_W-1:0];
    end else if (s1 < DMIN) begin
      wb_d1 = DMIN[DELAY_W-1:0];
    end else begin
      wb_d1 = s1[DELAY_W-1:0];
    end
    if (s2 > DMAX) begin
      wb_d2 = DMAX[DELAY_W-1:0];
    end else if (s2 < DMIN) begin
      wb_d2 = DMIN[DELAY_W-1:0];
    end else begin
      wb_d2 = s2[DELAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cur_r  <= x_sat;
      clip_r <= 1'b0;
    end else if (ctrl.acc) begin
      // stage output becomes next stage input and feedback operand
      cur_r  <= y_sat;
      clip_r <= clip_r | y_clip;
      d2_r   <= d2;
    end
    if (ctrl.mul_b) begin
      pb0_r <= rnd_q40(m0);
      pb1_r <= rnd_q40(m1);
      pb2_r <= rnd_q40(m2);
    end
    if (ctrl.mul_a) begin
      pa1_r <= rnd_q40(m0);
      pa2_r <= rnd_q40(m1);
    end
  end

  assign y    = cur_r;
  assign clip = clip_r;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for biquad_cascade_iir_filter_core. Drives coefficient
// loads, samples, clears and unused words with random gaps and output stalls,
// sweeps the stage count between phases, and checks each output word against
// a bit-exact fixed-point model of the cascade.
// ----------------------------------------------------------------------------
module testbench;
  import bqc_pkg::*;

  localparam int NUM_COEFS     = SLOTS * MAX_STAGES_DEF;
  localparam int NUM_DELAYS    = 2 * MAX_STAGES_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WORDS  = 1500;
  // Q0.23 x Q2.29 = Q.52, rounded half up to the Q.40 delay format
  localparam int PROD_DROP   = (SAMPLE_WIDTH_DEF - 1) + (COEF_WIDTH_DEF - 3) - DELAY_FRAC;
  // Q.40 back to the Q0.23 sample format
  localparam int ROUND_SHIFT = DELAY_FRAC - (SAMPLE_WIDTH_DEF - 1);

  localparam logic [OP_W-1:0]          OP_UNUSED  = 2'd3;
  localparam logic signed [SVAL_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SVAL_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [CVAL_W-1:0] COEF_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [CVAL_W-1:0] COEF_MIN   = 32'sh8000_0000;
  localparam longint DELAY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DELAY_MIN = -DELAY_MAX - 1;

  typedef enum int {STYLE_STABLE, STYLE_WILD, STYLE_EDGE} coef_style_t;

  typedef struct packed {
    logic signed [SVAL_W-1:0] sample;
    logic                     clipped;
  } chain_output_t;

  class biquad_chain;
    bit signed [CVAL_W-1:0]  coef_mem [NUM_COEFS];
    bit signed [DELAY_W-1:0] delay_mem [NUM_DELAYS];
    bit [CFG_W-1:0]          stage_count;
    chain_output_t           awaited_outputs [$];
    int                      mismatches;

    function new();
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (delay_mem[i]) delay_mem[i] = '0;
      stage_count = CFG_W'(CFG_RESET);
      mismatches  = 0;
    endfunction

    function void set_stage_count(bit [CFG_W-1:0] value);
      stage_count = value;
    endfunction

    function int pending();
      return awaited_outputs.size();
    endfunction

    function longint scaled_product(longint x, longint c);
      return (x * c + (64'sd1 <<< (PROD_DROP - 1))) >>> PROD_DROP;
    endfunction

    function bit signed [DELAY_W-1:0] sat_delay(longint v);
      if (v > DELAY_MAX) return DELAY_W'(DELAY_MAX);
      if (v < DELAY_MIN) return DELAY_W'(DELAY_MIN);
      return DELAY_W'(v);
    endfunction

    function chain_output_t filter_sample(logic signed [SVAL_W-1:0] sval);
      chain_output_t res;
      int n, s, base;
      longint x, y, acc, d1, d2;
      n = (stage_count == 0) ? 1 :
          ((stage_count > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(stage_count));
      x = longint'(sval);
      res.clipped = 1'b0;
      for (s = 0; s < n; s++) begin
        base = SLOTS * s;
        acc = scaled_product(x, coef_mem[base + SLOT_B0]) + delay_mem[2 * s];
        y = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (y > longint'(SAMPLE_MAX)) begin
          y = longint'(SAMPLE_MAX);
          res.clipped = 1'b1;
        end else if (y < longint'(SAMPLE_MIN)) begin
          y = longint'(SAMPLE_MIN);
          res.clipped = 1'b1;
        end
        d1 = scaled_product(x, coef_mem[base + SLOT_B1])
             - scaled_product(y, coef_mem[base + SLOT_A1]) + delay_mem[2 * s + 1];
        d2 = scaled_product(x, coef_mem[base + SLOT_B2])
             - scaled_product(y, coef_mem[base + SLOT_A2]);
        delay_mem[2 * s]     = sat_delay(d1);
        delay_mem[2 * s + 1] = sat_delay(d2);
        x = y;
      end
      res.sample = SVAL_W'(x);
      return res;
    endfunction

    function void take_word(logic [OP_W-1:0] op, logic [CIDX_W-1:0] idx,
                            logic signed [CVAL_W-1:0] cval,
                            logic signed [SVAL_W-1:0] sval);
      case (op)
        OP_LOAD: begin
          if (idx < NUM_COEFS) coef_mem[idx] = cval;
        end
        OP_SAMPLE: begin
          awaited_outputs.push_back(filter_sample(sval));
        end
        OP_CLEAR: begin
          foreach (delay_mem[i]) delay_mem[i] = '0;
        end
        default: ;
      endcase
    endfunction

    function void match_output(logic signed [SVAL_W-1:0] sample, logic clipped);
      chain_output_t want;
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected output word: sample %0d saturated %0b",
                 $time, sample, clipped);
        mismatches++;
        return;
      end
      want = awaited_outputs.pop_front();
      if (sample !== want.sample) begin
        $display("%0t: filtered_sample mismatch: expected %0d, actual %0d",
                 $time, want.sample, sample);
        mismatches++;
      end
      if (clipped !== want.clipped) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, want.clipped, clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation    = '0;
  logic [CIDX_W-1:0]        in_coef_index   = '0;
  logic signed [CVAL_W-1:0] in_coef_value   = '0;
  logic signed [SVAL_W-1:0] in_sample_value = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic signed [SVAL_W-1:0] out_filtered_sample;
  logic                     out_saturated;
  logic                     cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data     = '0;

  biquad_chain chain = new();
  bit          coef_loaded [NUM_COEFS];
  bit          calm_phase = 1'b0;
  int          stall_left = 0;

  biquad_cascade_iir_filter_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample),
    .out_saturated       (out_saturated),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CVAL_W-1:0] edge_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3:       return 32'sh2000_0000;
      4:       return 32'shE000_0000;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chain.match_output(out_filtered_sample, out_saturated);
  end

  // Called right after a rising edge; returns at the edge that accepts the word
  // with in_valid still high, so a following word can go out without a gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CIDX_W-1:0] idx,
                           input logic signed [CVAL_W-1:0] cval,
                           input logic signed [SVAL_W-1:0] sval);
    int gap;
    gap = calm_phase ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_coef_index   <= idx;
    in_coef_value   <= cval;
    in_sample_value <= sval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chain.take_word(op, idx, cval, sval);
    if (op == OP_LOAD && idx < NUM_COEFS) coef_loaded[idx] = 1'b1;
  endtask

  task automatic write_stage_count(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (chain.pending() != 0) @(posedge clk);
    // loads and clears leave no output word; let the core drain
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chain.set_stage_count(value);
  endtask

  task automatic load_design(input int stages, input bit reload);
    coef_style_t              style;
    logic signed [CVAL_W-1:0] vals [SLOTS];
    int                       a2, lim, s, k, r;
    bit                       missing;
    r = $urandom_range(0, 9);
    style = (r < 6) ? STYLE_STABLE : ((r < 8) ? STYLE_WILD : STYLE_EDGE);
    for (s = 0; s < stages; s++) begin
      missing = 1'b0;
      for (k = 0; k < SLOTS; k++) if (!coef_loaded[SLOTS * s + k]) missing = 1'b1;
      if (reload || missing) begin
        case (style)
          STYLE_STABLE: begin
            // |b| <= 0.5, poles kept inside the stability triangle
            a2  = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            lim = (1 << 29) + a2 - (1 << 26);
            vals[SLOT_B0] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            vals[SLOT_B1] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            vals[SLOT_B2] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            vals[SLOT_A1] = int'($urandom_range(0, 2 * lim)) - lim;
            vals[SLOT_A2] = a2;
          end
          STYLE_WILD: begin
            for (k = 0; k < SLOTS; k++) vals[k] = CVAL_W'($urandom);
          end
          default: begin
            for (k = 0; k < SLOTS; k++) vals[k] = edge_coef();
          end
        endcase
        for (k = 0; k < SLOTS; k++)
          send_word(OP_LOAD, CIDX_W'(SLOTS * s + k), vals[k], SVAL_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0]         first_counts [7];
    logic [CFG_W-1:0]         cnt;
    logic [CIDX_W-1:0]        idx;
    logic signed [CVAL_W-1:0] cval;
    logic signed [SVAL_W-1:0] sval;
    int                       words, phase, stages, phase_len, i, r;

    first_counts = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd1, 4'd9, 4'd5};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // one stage after reset: pass-through-ish stage 0
    send_word(OP_LOAD, 6'd0, 32'sh2000_0000, '0);
    send_word(OP_LOAD, 6'd1, 32'sh1000_0000, '0);
    send_word(OP_LOAD, 6'd2, 32'shF000_0000, '0);
    send_word(OP_LOAD, 6'd3, 32'shE000_0000, '0);
    send_word(OP_LOAD, 6'd4, 32'sh1000_0000, '0);
    send_word(OP_SAMPLE, '0, '0, SAMPLE_MAX);
    send_word(OP_SAMPLE, '0, '0, SAMPLE_MIN);
    send_word(OP_SAMPLE, '0, '0, '0);
    send_word(OP_SAMPLE, '0, '0, 24'sd1);
    send_word(OP_SAMPLE, '0, '0, -24'sd1);
    // indexes past the last stage are dropped
    send_word(OP_LOAD, 6'd40, COEF_MAX, '0);
    send_word(OP_LOAD, 6'd63, COEF_MIN, '0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_SAMPLE, '0, '0, SAMPLE_MAX);
    // extreme gains to force output clipping
    send_word(OP_LOAD, 6'd0, COEF_MAX, '0);
    send_word(OP_LOAD, 6'd3, COEF_MIN, '0);
    send_word(OP_LOAD, 6'd4, COEF_MAX, '0);
    send_word(OP_SAMPLE, '0, '0, SAMPLE_MIN);
    send_word(OP_SAMPLE, '0, '0, SAMPLE_MAX);
    send_word(OP_SAMPLE, '0, '0, 24'sd4096);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_SAMPLE, '0, '0, '0);

    words = 0;
    phase = 0;
    while (words < RANDOM_WORDS) begin
      cnt = (phase < 7) ? first_counts[phase] : CFG_W'($urandom_range(0, 15));
      calm_phase = 1'b0;
      write_stage_count(cnt);
      calm_phase = ($urandom_range(0, 3) == 0);
      stages = (cnt == 0) ? 1 : ((cnt > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(cnt));
      load_design(stages, 1'($urandom_range(0, 1)));
      phase_len = $urandom_range(60, 180);
      for (i = 0; i < phase_len; i++) begin
        r    = $urandom_range(0, 99);
        idx  = CIDX_W'($urandom);
        cval = CVAL_W'($urandom);
        sval = SVAL_W'($urandom);
        if (r < 72) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ;
            5, 6, 7: sval = SVAL_W'(int'($urandom_range(0, 8191)) - 4096);
            default: begin
              case ($urandom_range(0, 4))
                0:       sval = SAMPLE_MAX;
                1:       sval = SAMPLE_MIN;
                2:       sval = '0;
                3:       sval = 24'sd1;
                default: sval = -24'sd1;
              endcase
            end
          endcase
          send_word(OP_SAMPLE, idx, cval, sval);
          words++;
        end else if (r < 84) begin
          idx = CIDX_W'($urandom_range(0, SLOTS * stages - 1));
          case ($urandom_range(0, 9))
            0, 1:    cval = edge_coef();
            2, 3, 4: ;
            default: cval = int'($urandom_range(0, 1 << 29)) - (1 << 28);
          endcase
          send_word(OP_LOAD, idx, cval, sval);
          words++;
        end else if (r < 90) begin
          send_word(OP_CLEAR, idx, cval, sval);
          words++;
        end else if (r < 95) begin
          // any index, including ones past the last stage
          send_word(OP_LOAD, idx, cval, sval);
          if (idx < NUM_COEFS) words++;
        end else begin
          send_word(OP_UNUSED, idx, cval, sval);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (chain.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chain.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // worst case is near 2100 words; the timeout leaves a wide margin for them
  initial begin
    #25_000_000;
    $display("%0t: timeout, output words still awaited: %0d", $time, chain.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== biquad_cascade_iir_filter_core.f =====
rtl/bqc_pkg.sv
rtl/bqc_coef_mem.sv
rtl/bqc_dly_mem.sv
rtl/bqc_arith.sv
rtl/biquad_cascade_iir_filter_core.sv
sim/testbench.sv
